// ===== hw/rtl/sacr_pkg.sv =====
// Package for the sparse affine clipped-ReLU unit: request codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package sacr_pkg;

  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned BIAS_W   = 32;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned CLIP_W   = 7;
  localparam int unsigned CLIP_MAX = 127;

  typedef enum logic [1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_BIAS   = 2'd1,
    CMD_ACTIVATE    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic wr_weight;  // write one weight byte into its row
    logic wr_bias;    // write one bias register
    logic rd_row;     // read the weight row and capture the activation
    logic mac;        // update the accumulators
    logic init_acc;   // start the accumulators from the biases
    logic emit_load;  // load the output register with one result
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== hw/rtl/sacr_if.sv =====
// Valid/ready channel interfaces for requests and results of the unit.
// Depends on nothing.
interface sacr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  position;
  logic [3:0]  neuron;
  logic signed [7:0]  weight;
  logic signed [31:0] bias;
  logic signed [7:0]  activation;
  logic        final_input;

  modport source (
    output valid, command, position, neuron, weight, bias, activation, final_input,
    input  ready
  );
  modport sink (
    input  valid, command, position, neuron, weight, bias, activation, final_input,
    output ready
  );
endinterface

interface sacr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] neuron_index;
  logic [6:0] clipped_value;
  logic       final_result;

  modport source (
    output valid, neuron_index, clipped_value, final_result,
    input  ready
  );
  modport sink (
    input  valid, neuron_index, clipped_value, final_result,
    output ready
  );
endinterface

// ===== hw/rtl/sacr_ctrl.sv =====
// Controller state machine of the unit: accepts requests, sequences the
// accumulate step and the result emission. Depends on sacr_pkg.
module sacr_ctrl import sacr_pkg::*; #(
  parameter int unsigned NEURON_COUNT = 16,
  parameter int unsigned NIDX_W       = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_command_i,
  input  logic              in_final_i,
  output logic              in_ready_o,
  output dp_cmd_t           cmd_o,
  output logic [NIDX_W-1:0] emit_idx_o,
  input  dp_stat_t          stat_i
);

  localparam logic [NIDX_W-1:0] LastIdx = NIDX_W'(NEURON_COUNT - 1);

  state_e            state_q, state_d;
  logic              fresh_q, fresh_d;
  logic              final_q, final_d;
  logic [NIDX_W-1:0] idx_q, idx_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fresh_q <= 1'b1;
      final_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      final_q <= final_d;
      idx_q   <= idx_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    fresh_d    = fresh_q;
    final_d    = final_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    emit_idx_o = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_command_i)
            CMD_LOAD_WEIGHT: cmd_o.wr_weight = 1'b1;
            CMD_LOAD_BIAS:   cmd_o.wr_bias   = 1'b1;
            CMD_ACTIVATE: begin
              cmd_o.rd_row = 1'b1;
              final_d      = in_final_i;
              state_d      = ST_MAC;
            end
            default: ;  // unused code: drop the request
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac      = 1'b1;
        cmd_o.init_acc = fresh_q;
        fresh_d        = final_q;
        idx_d          = '0;
        state_d        = final_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          idx_d           = idx_q + NIDX_W'(1);
          if (idx_q == LastIdx) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load |-> stat_i.out_free)
    else $error("result loaded into a busy output register");

  a_activate_goes_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_command_i == CMD_ACTIVATE) |=> (state_q == ST_MAC))
    else $error("accepted activation did not reach the accumulate step");

  a_final_rearms_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && final_q) |=> (fresh_q && state_q == ST_EMIT))
    else $error("final activation did not end the pass");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("emission counter beyond the last neuron");

endmodule

// ===== hw/rtl/sacr_datapath.sv =====
// Datapath of the unit: weight row memory, bias registers, accumulator lanes
// with one 8x8 multiplier each, clip stage and output register.
// Depends on sacr_pkg.
module sacr_datapath import sacr_pkg::*; #(
  parameter int unsigned INPUT_COUNT  = 1024,
  parameter int unsigned NEURON_COUNT = 16,
  parameter int unsigned RESULT_SHIFT = 6,
  parameter int unsigned NIDX_W       = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic [NIDX_W-1:0]        emit_idx_i,
  output dp_stat_t                 stat_o,
  input  logic [9:0]               position_i,
  input  logic [3:0]               neuron_i,
  input  logic signed [7:0]        weight_i,
  input  logic signed [31:0]       bias_i,
  input  logic signed [7:0]        activation_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [3:0]               neuron_index_o,
  output logic [CLIP_W-1:0]        clipped_value_o,
  output logic                     final_result_o
);

  localparam int unsigned ADDR_W = $clog2(INPUT_COUNT);
  localparam int unsigned ROW_W  = NEURON_COUNT * WEIGHT_W;
  localparam logic [NIDX_W-1:0] LastIdx = NIDX_W'(NEURON_COUNT - 1);

  logic [ROW_W-1:0]         wmem_q [INPUT_COUNT];
  logic [ROW_W-1:0]         row_q;
  logic signed [BIAS_W-1:0] bias_q [NEURON_COUNT];
  logic signed [ACC_W-1:0]  acc_q  [NEURON_COUNT];
  logic signed [7:0]        act_q;
  logic                     add_en_q;

  logic              pos_ok, neu_ok;
  logic [ADDR_W-1:0] addr;
  logic [NIDX_W-1:0] lane;

  assign pos_ok = 32'(position_i) < 32'(INPUT_COUNT);
  assign neu_ok = 32'(neuron_i) < 32'(NEURON_COUNT);
  assign addr   = ADDR_W'(position_i);
  assign lane   = NIDX_W'(neuron_i);

  // Weight memory: one row per input position, one byte lane per neuron.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight && pos_ok && neu_ok) begin
      wmem_q[addr][lane*WEIGHT_W +: WEIGHT_W] <= weight_i;
    end
    if (cmd_i.rd_row) begin
      row_q <= wmem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_bias && neu_ok) begin
      bias_q[lane] <= bias_i;
    end
    if (cmd_i.rd_row) begin
      act_q    <= activation_i;
      add_en_q <= (activation_i != '0) && pos_ok;
    end
  end

  // Accumulator lanes.
  for (genvar n = 0; n < NEURON_COUNT; n++) begin : g_lane
    logic signed [WEIGHT_W-1:0] w;
    logic signed [15:0]         prod;
    logic signed [ACC_W-1:0]    base, acc_d;

    assign w     = row_q[n*WEIGHT_W +: WEIGHT_W];
    assign prod  = act_q * w;
    assign base  = cmd_i.init_acc ? bias_q[n] : acc_q[n];
    assign acc_d = base + (add_en_q ? ACC_W'(prod) : '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[n] <= '0;
      end else if (cmd_i.mac) begin
        acc_q[n] <= acc_d;
      end
    end
  end

  // Clip stage: arithmetic shift, clamp to 0..CLIP_MAX.
  logic signed [ACC_W-1:0] shifted;
  logic [CLIP_W-1:0]       clip;

  assign shifted = acc_q[emit_idx_i] >>> RESULT_SHIFT;

  always_comb begin
    if (shifted < 0) begin
      clip = '0;
    end else if (shifted > ACC_W'(CLIP_MAX)) begin
      clip = CLIP_W'(CLIP_MAX);
    end else begin
      clip = shifted[CLIP_W-1:0];
    end
  end

  // Output register.
  logic              out_valid_q;
  logic [3:0]        nidx_q;
  logic [CLIP_W-1:0] clip_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      nidx_q <= 4'(emit_idx_i);
      clip_q <= clip;
      last_q <= (emit_idx_i == LastIdx);
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign neuron_index_o  = nidx_q;
  assign clipped_value_o = clip_q;
  assign final_result_o  = last_q;

endmodule

// ===== hw/rtl/sparse_affine_clipped_relu_unit.sv =====
// Top level of the sparse affine clipped-ReLU unit: joins controller and
// datapath. Depends on sacr_pkg, sacr_in_if, sacr_out_if, sacr_ctrl, sacr_datapath.
//
// Use: requests arrive on in_i (valid/ready). A weight-load request writes one
// signed byte into the weight row of its position; a bias-load request writes
// one 32-bit bias. An activation request reads the weight row of its position
// (one memory port, one row per cycle) and in the following cycle updates all
// NEURON_COUNT accumulators in parallel; the unit takes no new request until
// that accumulate step is done. The first activation after a finished pass
// starts the accumulators from the biases; zero activations and positions
// beyond the store add nothing.
// An activation marked final then emits NEURON_COUNT results on out_o, one
// per cycle through a single output register, index 0 first; the last one
// carries final_result. After the accumulate step, the emit state loads the
// first result into the output register. No request is taken during emission;
// the unit takes the next one once the last result sits in the output register.
// When the receiver stalls, the held result stays put and emission waits.
// Reset clears the accumulators and starts a fresh pass; the weight memory
// and biases hold nothing defined until written.
module sparse_affine_clipped_relu_unit import sacr_pkg::*; #(
  parameter int unsigned INPUT_COUNT  = 1024,
  parameter int unsigned NEURON_COUNT = 16,
  parameter int unsigned RESULT_SHIFT = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sacr_in_if.sink     in_i,
  sacr_out_if.source  out_o
);

  localparam int unsigned NIDX_W = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [NIDX_W-1:0] emit_idx;

  // Controller: hold the handshake and sequence each request.
  sacr_ctrl #(
    .NEURON_COUNT (NEURON_COUNT),
    .NIDX_W       (NIDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_final_i   (in_i.final_input),
    .in_ready_o   (in_i.ready),
    .cmd_o        (cmd),
    .emit_idx_o   (emit_idx),
    .stat_i       (stat)
  );

  // Datapath: stores, accumulator lanes and output register.
  sacr_datapath #(
    .INPUT_COUNT  (INPUT_COUNT),
    .NEURON_COUNT (NEURON_COUNT),
    .RESULT_SHIFT (RESULT_SHIFT),
    .NIDX_W       (NIDX_W)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .emit_idx_i      (emit_idx),
    .stat_o          (stat),
    .position_i      (in_i.position),
    .neuron_i        (in_i.neuron),
    .weight_i        (in_i.weight),
    .bias_i          (in_i.bias),
    .activation_i    (in_i.activation),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .neuron_index_o  (out_o.neuron_index),
    .clipped_value_o (out_o.clipped_value),
    .final_result_o  (out_o.final_result)
  );

endmodule
